@@ hw/rtl/rcib_pkg.sv @@
// Shared types, constants and the cosine weight function for the radial blend core.
`default_nettype none

package rcib_pkg;

    // Channel and register widths
    localparam int CH_W         = 8;
    localparam int CFG_COORD_W  = 12;
    localparam int CFG_RADIUS_W = 25;
    localparam int CFG_DATA_W   = 25;
    localparam int CFG_INDEX_W  = 2;
    localparam int PHASE_W      = 17;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER_X   = 2'd0,
        CFG_CENTER_Y   = 2'd1,
        CFG_INV_RADIUS = 2'd2
    } cfg_index_t;

    localparam logic [CFG_COORD_W-1:0]  RST_CENTER_X   = 12'd32;
    localparam logic [CFG_COORD_W-1:0]  RST_CENTER_Y   = 12'd32;
    localparam logic [CFG_RADIUS_W-1:0] RST_INV_RADIUS = 25'd370728;

    // Phase of 1.0 in 16 fraction bits
    localparam logic [PHASE_W-1:0] PHASE_ONE = 17'h10000;

    // Q28 constants for the table build
    localparam logic [63:0] Q28_ONE = 64'h0000_0000_1000_0000;
    localparam logic [63:0] PI_Q28  = 64'd843314857;

    // Pixel pair carried alongside the distance datapath
    typedef struct packed {
        logic [CH_W-1:0] a_blue;
        logic [CH_W-1:0] a_green;
        logic [CH_W-1:0] a_red;
        logic [CH_W-1:0] b_blue;
        logic [CH_W-1:0] b_green;
        logic [CH_W-1:0] b_red;
    } pix_t;

    // Result word, packed so that out_blue sits in the lowest bits
    typedef struct packed {
        logic [CH_W-1:0] weight;
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
    } res_t;

    // Raised-cosine weight for a Q28 angle t in [0, pi/2]; far_half mirrors
    // the curve for the second half of the table. Evaluated at elaboration.
    function automatic logic [CH_W-1:0] cos_weight(input logic [63:0] t,
                                                   input logic        far_half);
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] c;
        logic [63:0] num;
        logic [63:0] scaled;
        longint      sum;
        t2   = (t * t) >> 28;
        term = Q28_ONE;
        sum  = longint'(Q28_ONE);
        term = ((term * t2) >> 28) / 64'd2;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 28) / 64'd12;
        sum  = sum + longint'(term);
        term = ((term * t2) >> 28) / 64'd30;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 28) / 64'd56;
        sum  = sum + longint'(term);
        term = ((term * t2) >> 28) / 64'd90;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 28) / 64'd132;
        sum  = sum + longint'(term);
        term = ((term * t2) >> 28) / 64'd182;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 28) / 64'd240;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(Q28_ONE)) begin
            sum = longint'(Q28_ONE);
        end
        c      = 64'(sum);
        num    = far_half ? (Q28_ONE - c) : (Q28_ONE + c);
        scaled = (64'd255 * num) >> 29;
        return scaled[CH_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/radial_cosine_image_blend_core.sv @@
// Top level of the radial raised-cosine blend core: front end, phase, table, output buffer.
`default_nettype none

// Blends two RGB pixels with a weight that falls off as a raised cosine of the
// distance from a programmable centre. Each input word carries a pixel position
// and the matching pixels of images A and B; each output word carries the three
// blended channels and the weight applied to A (255 at the centre, 0 at and
// beyond the radius). The core is a fixed pipeline that takes one word per clock
// and sustains one result per clock while the output buffer's spare entry is
// free; its depth varies with COORD_BITS through the square-root stages, which
// resolve two root bits each. Multipliers of at most 32 bits in the distance path
// stand in their own stages (squares, radius scaling, table index), the weight table is
// read through a register, and a two-entry output buffer lets the pipeline keep
// taking words while a finished result waits for m_tready. Program center_x,
// center_y and inv_radius (2^24 over the centre-to-corner distance) only while
// the core is idle; an inv_radius of zero gives a weight of 255 everywhere.
module radial_cosine_image_blend_core import rcib_pkg::*; #(
    parameter int COORD_BITS      = 12,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  wire                     aclk,
    input  wire                     aresetn,

    // Configuration write port
    input  wire                     cfg_wr_en,
    input  wire  [CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0]   cfg_wdata,

    // Input words
    input  wire                     s_tvalid,
    output logic                    s_tready,
    // column, row, a_blue, a_green, a_red, b_blue, b_green, b_red, zero fill
    input  wire  [((2*COORD_BITS+6*8+7)/8)*8-1:0] s_tdata,

    // Result words
    output logic                    m_tvalid,
    input  wire                     m_tready,
    // out_blue, out_green, out_red, weight
    output logic [4*CH_W-1:0]       m_tdata
);

    localparam int DX_W    = (COORD_BITS > CFG_COORD_W) ? COORD_BITS : CFG_COORD_W;
    localparam int SQ_W    = 2 * DX_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int ROOT_W  = ((SUM_W + 19) / 4) * 2;
    localparam int PROD_W  = ROOT_W + CFG_RADIUS_W;
    localparam int RAW_W   = PROD_W - 16;
    localparam int KW      = $clog2(COS_TABLE_DEPTH);
    localparam int KS_W    = PHASE_W + KW;
    localparam int PIX_LSB = 2 * COORD_BITS;

    localparam logic [KW-1:0]   K_LAST   = KW'(COS_TABLE_DEPTH - 1);
    localparam logic [KS_W-1:0] K_ROUND  = KS_W'(32768);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_COORD_W-1:0]  center_x_reg;
    logic [CFG_COORD_W-1:0]  center_y_reg;
    logic [CFG_RADIUS_W-1:0] inv_radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg   <= RST_CENTER_X;
            center_y_reg   <= RST_CENTER_Y;
            inv_radius_reg <= RST_INV_RADIUS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CENTER_X:   center_x_reg   <= cfg_wdata[CFG_COORD_W-1:0];
                CFG_CENTER_Y:   center_y_reg   <= cfg_wdata[CFG_COORD_W-1:0];
                CFG_INV_RADIUS: inv_radius_reg <= cfg_wdata[CFG_RADIUS_W-1:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline advances together while the output
    // buffer still has its spare entry free.
    // ------------------------------------------------------------------
    logic en;
    logic sk_valid_reg;
    logic m_valid_reg;

    assign en       = !sk_valid_reg;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: capture the word
    // ------------------------------------------------------------------
    logic                  p1_v_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] row_reg;
    pix_t                  pix1_reg;
    pix_t                  s_pix;

    assign s_pix.a_blue  = s_tdata[PIX_LSB +  0 +: CH_W];
    assign s_pix.a_green = s_tdata[PIX_LSB +  8 +: CH_W];
    assign s_pix.a_red   = s_tdata[PIX_LSB + 16 +: CH_W];
    assign s_pix.b_blue  = s_tdata[PIX_LSB + 24 +: CH_W];
    assign s_pix.b_green = s_tdata[PIX_LSB + 32 +: CH_W];
    assign s_pix.b_red   = s_tdata[PIX_LSB + 40 +: CH_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            col_reg  <= s_tdata[COORD_BITS-1:0];
            row_reg  <= s_tdata[COORD_BITS +: COORD_BITS];
            pix1_reg <= s_pix;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: offsets from the centre, as magnitudes
    // ------------------------------------------------------------------
    logic            p2_v_reg;
    logic [DX_W-1:0] dx_reg;
    logic [DX_W-1:0] dy_reg;
    pix_t            pix2_reg;
    logic [DX_W-1:0] col_ext, row_ext, cx_ext, cy_ext;
    logic [DX_W-1:0] dx_next, dy_next;

    assign col_ext = DX_W'(col_reg);
    assign row_ext = DX_W'(row_reg);
    assign cx_ext  = DX_W'(center_x_reg);
    assign cy_ext  = DX_W'(center_y_reg);
    assign dx_next = (col_ext >= cx_ext) ? (col_ext - cx_ext) : (cx_ext - col_ext);
    assign dy_next = (row_ext >= cy_ext) ? (row_ext - cy_ext) : (cy_ext - row_ext);

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            pix2_reg <= pix1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squares
    // ------------------------------------------------------------------
    logic            p3_v_reg;
    logic [SQ_W-1:0] sqx_reg;
    logic [SQ_W-1:0] sqy_reg;
    pix_t            pix3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg  <= dx_reg * dx_reg;
            sqy_reg  <= dy_reg * dy_reg;
            pix3_reg <= pix2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squared distance
    // ------------------------------------------------------------------
    logic             p4_v_reg;
    logic [SUM_W-1:0] dsq_reg;
    pix_t             pix4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dsq_reg  <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
            pix4_reg <= pix3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root: distance with 8 fraction bits, truncated
    // ------------------------------------------------------------------
    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    pix_t              sq_pix;

    rcib_isqrt #(
        .IN_W (SUM_W)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p4_v_reg),
        .in_sum    (dsq_reg),
        .in_pix    (pix4_reg),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_pix   (sq_pix)
    );

    // ------------------------------------------------------------------
    // Stage 5: scale by the reciprocal radius
    // ------------------------------------------------------------------
    logic              p5_v_reg;
    logic [PROD_W-1:0] rprod_reg;
    pix_t              pix5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rprod_reg <= PROD_W'(sq_root) * PROD_W'(inv_radius_reg);
            pix5_reg  <= sq_pix;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: phase in half turns, clamp at 1.0
    // ------------------------------------------------------------------
    logic               p6_v_reg;
    logic [PHASE_W-1:0] phase_reg;
    pix_t               pix6_reg;
    logic [RAW_W-1:0]   phase_raw;
    logic [PHASE_W-1:0] phase_next;

    assign phase_raw  = rprod_reg[PROD_W-1:16];
    assign phase_next = (phase_raw > RAW_W'(PHASE_ONE)) ? PHASE_ONE
                                                        : phase_raw[PHASE_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            phase_reg <= phase_next;
            pix6_reg  <= pix5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: table index, rounded to nearest entry
    // ------------------------------------------------------------------
    logic            p7_v_reg;
    logic [KW-1:0]   k_reg;
    pix_t            pix7_reg;
    logic [KS_W-1:0] k_sum;

    assign k_sum = KS_W'(phase_reg) * KS_W'(K_LAST) + K_ROUND;

    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg    <= k_sum[16 +: KW];
            pix7_reg <= pix6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: weight table read
    // ------------------------------------------------------------------
    logic            r_v_reg;
    pix_t            pixr_reg;
    logic [CH_W-1:0] weight;

    rcib_cos_rom #(
        .DEPTH (COS_TABLE_DEPTH)
    ) u_cos_rom (
        .aclk (aclk),
        .en   (en),
        .addr (k_reg),
        .data (weight)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            pixr_reg <= pix7_reg;
        end
    end

    // Valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
            p6_v_reg <= 1'b0;
            p7_v_reg <= 1'b0;
            r_v_reg  <= 1'b0;
        end else if (en) begin
            p1_v_reg <= s_tvalid;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= sq_v;
            p6_v_reg <= p5_v_reg;
            p7_v_reg <= p6_v_reg;
            r_v_reg  <= p7_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 9-10: blend
    // ------------------------------------------------------------------
    logic bl_v;
    res_t bl_res;

    rcib_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_v_reg),
        .in_pix    (pixr_reg),
        .in_weight (weight),
        .out_valid (bl_v),
        .out_res   (bl_res)
    );

    // ------------------------------------------------------------------
    // Output buffer: main register plus one spare entry. The pipeline
    // pushes whenever it advances with a valid word at its end.
    // ------------------------------------------------------------------
    logic push;
    res_t m_res_reg;
    res_t sk_res_reg;

    assign push = en && bl_v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            // main register free: refill from the spare entry first
            m_valid_reg  <= sk_valid_reg || push;
            sk_valid_reg <= 1'b0;
        end else if (push) begin
            // stalled with a word waiting: park the new one
            sk_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            m_res_reg <= sk_valid_reg ? sk_res_reg : bl_res;
        end else if (push) begin
            sk_res_reg <= bl_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_phase_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        p6_v_reg |-> (phase_reg <= PHASE_ONE))
        else $error("phase above 1.0 after clamp");

    a_index_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        p7_v_reg |-> (k_reg <= K_LAST))
        else $error("table index beyond last entry");

    a_spare_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_valid_reg |-> m_valid_reg)
        else $error("spare entry holds a word while main register is empty");

    a_spare_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(sk_valid_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("spare entry filled without an output stall");

endmodule

`default_nettype wire

@@ hw/rtl/rcib_isqrt.sv @@
// Pipelined integer square root of (sum << 16), two result bits per stage.
`default_nettype none

module rcib_isqrt import rcib_pkg::*; #(
    parameter int IN_W = 25
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            en,
    input  wire                            in_valid,
    input  wire  [IN_W-1:0]                in_sum,
    input  pix_t                           in_pix,
    output logic                           out_valid,
    output logic [((IN_W+19)/4)*2-1:0]     out_root,
    output pix_t                           out_pix
);

    localparam int STAGES = (IN_W + 19) / 4;
    localparam int NP     = 4 * STAGES;
    localparam int ROOT_W = NP / 2;
    localparam int RW     = ROOT_W + 2;

    logic              v_reg   [STAGES];
    logic [RW-1:0]     rem_reg [STAGES];
    logic [ROOT_W-1:0] q_reg   [STAGES];
    logic [NP-1:0]     op_reg  [STAGES];
    pix_t              pix_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic              v_in;
        logic [RW-1:0]     rem_in;
        logic [ROOT_W-1:0] q_in;
        logic [NP-1:0]     op_in;
        pix_t              pix_in;
        logic [RW-1:0]     rem_next;
        logic [ROOT_W-1:0] q_next;
        logic [NP-1:0]     op_next;

        if (s == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = '0;
            assign q_in   = '0;
            assign op_in  = NP'({in_sum, 16'd0});
            assign pix_in = in_pix;
        end else begin : g_next
            assign v_in   = v_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign op_in  = op_reg[s-1];
            assign pix_in = pix_reg[s-1];
        end

        // Two restoring steps: bring down a bit pair, try subtracting 4q+1
        always_comb begin
            logic [RW-1:0]     rv;
            logic [ROOT_W-1:0] qv;
            logic [NP-1:0]     ov;
            logic [RW-1:0]     trial;
            rv = rem_in;
            qv = q_in;
            ov = op_in;
            for (int i = 0; i < 2; i++) begin
                rv    = {rv[RW-3:0], ov[NP-1 -: 2]};
                ov    = {ov[NP-3:0], 2'b00};
                trial = {qv, 2'b01};
                if (rv >= trial) begin
                    rv = rv - trial;
                    qv = {qv[ROOT_W-2:0], 1'b1};
                end else begin
                    qv = {qv[ROOT_W-2:0], 1'b0};
                end
            end
            rem_next = rv;
            q_next   = qv;
            op_next  = ov;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                q_reg[s]   <= q_next;
                op_reg[s]  <= op_next;
                pix_reg[s] <= pix_in;
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_root  = q_reg[STAGES-1];
    assign out_pix   = pix_reg[STAGES-1];

endmodule

`default_nettype wire

@@ hw/rtl/rcib_cos_rom.sv @@
// Raised-cosine weight table built at elaboration, with a registered read port.
`default_nettype none

module rcib_cos_rom import rcib_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  wire                       aclk,
    input  wire                       en,
    input  wire  [$clog2(DEPTH)-1:0]  addr,
    output logic [CH_W-1:0]           data
);

    localparam int LAST = DEPTH - 1;

    logic [CH_W-1:0] rom [DEPTH];
    logic [CH_W-1:0] data_reg;

    for (genvar gk = 0; gk < DEPTH; gk++) begin : g_entry
        localparam bit          FAR = (2 * gk) > LAST;
        localparam int          M   = FAR ? (LAST - gk) : gk;
        localparam logic [63:0] TQ  = (PI_Q28 * 64'(M)) / 64'(LAST);
        assign rom[gk] = cos_weight(TQ, FAR);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= rom[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rcib_blend.sv @@
// Two-stage weighted blend of the pixel pair: products, then rounding and saturation.
`default_nettype none

module rcib_blend import rcib_pkg::*; (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  pix_t                in_pix,
    input  wire  [CH_W-1:0]     in_weight,
    output logic                out_valid,
    output res_t                out_res
);

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // round(p / 255) for p = x * w, as floor((p + 127) / 255)
    function automatic logic [CH_W-1:0] div255_round(input logic [2*CH_W-1:0] p);
        logic [2*CH_W-1:0] y;
        logic [2*CH_W-1:0] s;
        y = p + 16'd127;
        s = y + 16'd1 + {8'd0, y[2*CH_W-1:CH_W]};
        return s[2*CH_W-1:CH_W];
    endfunction

    logic [CH_W-1:0]   a_ch [3];
    logic [CH_W-1:0]   b_ch [3];
    logic [CH_W-1:0]   w_inv;

    logic              v1_reg;
    logic [2*CH_W-1:0] prod_a_reg [3];
    logic [2*CH_W-1:0] prod_b_reg [3];
    logic [CH_W-1:0]   w1_reg;

    logic              v2_reg;
    logic [CH_W-1:0]   ch_next [3];
    res_t              res_reg;

    assign a_ch[0] = in_pix.a_blue;
    assign a_ch[1] = in_pix.a_green;
    assign a_ch[2] = in_pix.a_red;
    assign b_ch[0] = in_pix.b_blue;
    assign b_ch[1] = in_pix.b_green;
    assign b_ch[2] = in_pix.b_red;
    assign w_inv   = CH_MAX - in_weight;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                prod_a_reg[c] <= a_ch[c] * in_weight;
                prod_b_reg[c] <= b_ch[c] * w_inv;
            end
            w1_reg <= in_weight;
        end
    end

    // Sum the rounded terms, clamp at full scale
    always_comb begin
        logic [CH_W:0] total;
        for (int c = 0; c < 3; c++) begin
            total = {1'b0, div255_round(prod_a_reg[c])}
                  + {1'b0, div255_round(prod_b_reg[c])};
            ch_next[c] = total[CH_W] ? CH_MAX : total[CH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.out_blue  <= ch_next[0];
            res_reg.out_green <= ch_next[1];
            res_reg.out_red   <= ch_next[2];
            res_reg.weight    <= w1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire
